[src/stdict_pkg.sv]
package stdict_pkg;

  localparam int unsigned CapacityDefault  = 16;
  localparam int unsigned ValueBitsDefault = 32;

  typedef enum logic [1:0] {
    KIND_LOOKUP = 2'd0,
    KIND_INSERT = 2'd1,
    KIND_DELETE = 2'd2,
    KIND_SPARE  = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_UPDATED   = 3'd1,
    ST_FOUND     = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_DELETED   = 3'd4,
    ST_FULL      = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    CM_HOLD,
    CM_FROM_LOWER,
    CM_FROM_UPPER,
    CM_LOAD,
    CM_SET_VALUE
  } cell_mode_e;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [31:0] key;
    logic [31:0]        value_in;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] value_out;
    logic [3:0]  position;
    logic [4:0]  entries_held;
  } rsp_t;

  typedef struct packed {
    logic       cmp_en;
    cell_mode_e mode;
  } cell_ctl_t;

  typedef struct packed {
    logic lt;
    logic eq;
  } cell_flag_t;

endpackage

[src/stdict_cell.sv]
module stdict_cell import stdict_pkg::*; #(
  parameter int unsigned VALUE_BITS = ValueBitsDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cell_ctl_t             ctl_i,
  input  logic signed [31:0]    new_key_i,
  input  logic [VALUE_BITS-1:0] new_value_i,
  input  logic signed [31:0]    lo_key_i,
  input  logic [VALUE_BITS-1:0] lo_value_i,
  input  logic signed [31:0]    up_key_i,
  input  logic [VALUE_BITS-1:0] up_value_i,
  output logic signed [31:0]    key_o,
  output logic [VALUE_BITS-1:0] value_o,
  output cell_flag_t            flag_o
);

  logic signed [31:0]    key_q, key_d;
  logic [VALUE_BITS-1:0] value_q, value_d;
  cell_flag_t            flag_q;

  always_comb begin
    key_d   = key_q;
    value_d = value_q;
    case (ctl_i.mode)
      CM_HOLD: begin
      end
      CM_FROM_LOWER: begin
        key_d   = lo_key_i;
        value_d = lo_value_i;
      end
      CM_FROM_UPPER: begin
        key_d   = up_key_i;
        value_d = up_value_i;
      end
      CM_LOAD: begin
        key_d   = new_key_i;
        value_d = new_value_i;
      end
      CM_SET_VALUE: begin
        value_d = new_value_i;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    value_q <= value_d;
  end

  // compare flags: stored key below or equal to the probe key
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flag_q <= '0;
    end else if (ctl_i.cmp_en) begin
      flag_q.lt <= key_q < new_key_i;
      flag_q.eq <= key_q == new_key_i;
    end
  end

  assign key_o   = key_q;
  assign value_o = value_q;
  assign flag_o  = flag_q;

endmodule

[src/sorted_table_dictionary.sv]
// Sorted table dictionary: a row of key/value cells kept in ascending signed key order.
// The result word is registered after the accept, compare and apply steps; apply waits
// for a free output register. A new word is taken only once the previous one is applied.
// Reset clears the fill count, the control state and the output valid; cell contents
// stay undefined until written, and only cells below the fill count are ever used.
module sorted_table_dictionary import stdict_pkg::*; #(
  parameter int unsigned CAPACITY   = CapacityDefault,
  parameter int unsigned VALUE_BITS = ValueBitsDefault
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  req_t in_word_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output rsp_t out_word_o
);

  localparam int unsigned IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_CMP   = 3'b010,
    S_APPLY = 3'b100
  } state_e;

  state_e           state_q, state_d;
  req_t             op_q;
  logic [CW-1:0]    fill_q, fill_d;
  logic             out_valid_q;
  rsp_t             rsp_q;

  // Cell row wiring.
  cell_ctl_t             ctl      [CAPACITY];
  cell_flag_t            flag     [CAPACITY];
  logic signed [31:0]    cell_key [CAPACITY];
  logic [VALUE_BITS-1:0] cell_val [CAPACITY];
  logic [CAPACITY-1:0]   below;    // occupied and key below the probe
  logic [CAPACITY-1:0]   at_pt;    // the insertion / match point
  logic [CAPACITY-1:0]   above_pt; // cells past the point
  logic [CAPACITY-1:0]   match;    // occupied and key equal

  logic [63:0]           new_wide;
  logic [VALUE_BITS-1:0] new_value;

  logic                  accept, apply_go;
  logic                  hit, full;
  logic                  do_insert, do_update, do_delete;
  logic [IW-1:0]         point_idx;
  logic [VALUE_BITS-1:0] hit_value;
  logic [63:0]           hit_wide;
  logic [31:0]           pos_wide, cnt_wide;
  rsp_t                  rsp_d;

  // Payload is kept in VALUE_BITS bits: zero extend or truncate the 32-bit field.
  assign new_wide  = 64'(op_q.value_in);
  assign new_value = new_wide[VALUE_BITS-1:0];

  assign accept   = in_valid_i && !in_stall_o;
  assign apply_go = (state_q == S_APPLY) && (!out_valid_q || !out_stall_i);

  // Per-cell point detection from the thermometer of "below" flags; only neighbors matter.
  for (genvar j = 0; j < CAPACITY; j++) begin : g_pt
    logic prev_below;
    assign below[j] = flag[j].lt && (CW'(j) < fill_q);
    assign match[j] = flag[j].eq && (CW'(j) < fill_q);
    if (j == 0) begin : g_first
      assign prev_below = 1'b1;
    end else begin : g_rest
      assign prev_below = below[j-1];
    end
    assign at_pt[j]    = prev_below && !below[j];
    assign above_pt[j] = !prev_below;
  end

  assign hit  = |match;
  assign full = (fill_q == CW'(CAPACITY));

  assign do_insert = (op_q.kind == KIND_INSERT) && !hit && !full;
  assign do_update = (op_q.kind == KIND_INSERT) && hit;
  assign do_delete = (op_q.kind == KIND_DELETE) && hit;

  // Encode the one-hot point and pick the matching value.
  always_comb begin
    point_idx = '0;
    hit_value = '0;
    for (int unsigned j = 0; j < CAPACITY; j++) begin
      if (at_pt[j]) begin
        point_idx = point_idx | IW'(j);
      end
      if (match[j]) begin
        hit_value = hit_value | cell_val[j];
      end
    end
  end

  // Cell commands.
  for (genvar j = 0; j < CAPACITY; j++) begin : g_ctl
    always_comb begin
      ctl[j].cmp_en = (state_q == S_CMP);
      ctl[j].mode   = CM_HOLD;
      if (apply_go) begin
        if (do_insert && at_pt[j]) begin
          ctl[j].mode = CM_LOAD;
        end else if (do_insert && above_pt[j]) begin
          ctl[j].mode = CM_FROM_LOWER;
        end else if (do_update && at_pt[j]) begin
          ctl[j].mode = CM_SET_VALUE;
        end else if (do_delete && (at_pt[j] || above_pt[j])) begin
          ctl[j].mode = CM_FROM_UPPER;
        end
      end
    end
  end

  // The row of cells; ends feed back the probe pair or their own content.
  for (genvar j = 0; j < CAPACITY; j++) begin : g_cell
    logic signed [31:0]    lo_key, up_key;
    logic [VALUE_BITS-1:0] lo_val, up_val;
    if (j == 0) begin : g_lo_end
      assign lo_key = op_q.key;
      assign lo_val = new_value;
    end else begin : g_lo
      assign lo_key = cell_key[j-1];
      assign lo_val = cell_val[j-1];
    end
    if (j == CAPACITY - 1) begin : g_up_end
      assign up_key = cell_key[j];
      assign up_val = cell_val[j];
    end else begin : g_up
      assign up_key = cell_key[j+1];
      assign up_val = cell_val[j+1];
    end

    stdict_cell #(
      .VALUE_BITS (VALUE_BITS)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctl_i       (ctl[j]),
      .new_key_i   (op_q.key),
      .new_value_i (new_value),
      .lo_key_i    (lo_key),
      .lo_value_i  (lo_val),
      .up_key_i    (up_key),
      .up_value_i  (up_val),
      .key_o       (cell_key[j]),
      .value_o     (cell_val[j]),
      .flag_o      (flag[j])
    );
  end

  // Result and next fill count.
  always_comb begin
    fill_d   = fill_q;
    rsp_d    = '0;
    rsp_d.status = ST_NOT_FOUND;
    pos_wide = 32'(point_idx);
    hit_wide = 64'(hit_value);
    case (op_q.kind)
      KIND_INSERT: begin
        if (hit) begin
          rsp_d.status   = ST_UPDATED;
          rsp_d.position = pos_wide[3:0];
        end else if (full) begin
          rsp_d.status = ST_FULL;
        end else begin
          rsp_d.status   = ST_INSERTED;
          rsp_d.position = pos_wide[3:0];
          fill_d         = fill_q + CW'(1);
        end
      end
      KIND_DELETE: begin
        if (hit) begin
          rsp_d.status   = ST_DELETED;
          rsp_d.position = pos_wide[3:0];
          fill_d         = fill_q - CW'(1);
        end
      end
      default: begin
        // lookup, spare code included
        if (hit) begin
          rsp_d.status    = ST_FOUND;
          rsp_d.position  = pos_wide[3:0];
          rsp_d.value_out = hit_wide[31:0];
        end
      end
    endcase
    cnt_wide           = 32'(fill_d);
    rsp_d.entries_held = cnt_wide[4:0];
  end

  // Sequencer: accept, compare, apply (apply waits for a free output register).
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_CMP;
        end
      end
      S_CMP: begin
        state_d = S_APPLY;
      end
      S_APPLY: begin
        if (apply_go) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (apply_go) begin
        fill_q      <= fill_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q <= in_word_i;
    end
    if (apply_go) begin
      rsp_q <= rsp_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_word_o  = rsp_q;

endmodule

[tb/sv/sorted_table_dictionary_test.sv]
`timescale 1ns / 1ps

module sorted_table_dictionary_test;
  import stdict_pkg::*;

  localparam int unsigned Capacity   = CapacityDefault;
  localparam int unsigned PoolSize   = 24;
  localparam int unsigned RandWords  = 750;
  localparam int unsigned CycleLimit = 200000;

  localparam logic signed [31:0] KeyMin = 32'sh8000_0000;
  localparam logic signed [31:0] KeyMax = 32'sh7fff_ffff;

  // One directed operation: the word to send and, where it is obvious, the answer.
  typedef struct packed {
    req_t word;
    logic typed;
    rsp_t answer;
  } probe_row_t;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  req_t in_word_i;
  logic out_valid_o;
  logic out_stall_i;
  rsp_t out_word_o;

  // Shadow copy of the dictionary contents, kept in sorted slot order.
  logic signed [31:0] held_keys   [Capacity];
  logic [31:0]        held_values [Capacity];
  int unsigned        held_count;
  int unsigned        peak_count;

  logic signed [31:0] key_pool [PoolSize];
  probe_row_t         probe_rows [$];
  rsp_t               awaited_answers [$];

  int unsigned cycle_count;
  int unsigned fail_count;
  int unsigned words_sent;
  int unsigned words_checked;
  int unsigned outcome_seen [6];
  int unsigned stall_mode;
  int unsigned stall_span;

  sorted_table_dictionary dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Abort a hung run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Timeout after %0d cycles, %0d answers still awaited",
               cycle_count, awaited_answers.size());
      $display("** sorted_table_dictionary: FAILED **");
      $finish;
    end
  end

  // Apply one operation to the shadow dictionary and return the answer it earns.
  // Walk to the first slot whose key is not below the requested key; a hit is
  // an exact match there. Unused kind code falls through to a plain lookup.
  function automatic rsp_t dict_apply(req_t w);
    rsp_t        r;
    int unsigned slot;
    int unsigned j;
    bit          hit;
    r = '0;
    r.status = ST_NOT_FOUND;
    slot = 0;
    while (slot < held_count && $signed(held_keys[slot]) < $signed(w.key))
      slot++;
    hit = (slot < held_count) && (held_keys[slot] == w.key);
    case (w.kind)
      KIND_INSERT: begin
        if (hit) begin
          held_values[slot] = w.value_in;
          r.status = ST_UPDATED;
          r.position = slot[3:0];
        end else if (held_count >= Capacity) begin
          r.status = ST_FULL;
        end else begin
          // Open a hole at the insertion point by moving larger keys up.
          for (j = held_count; j > slot; j--) begin
            held_keys[j]   = held_keys[j - 1];
            held_values[j] = held_values[j - 1];
          end
          held_keys[slot]   = w.key;
          held_values[slot] = w.value_in;
          held_count++;
          r.status = ST_INSERTED;
          r.position = slot[3:0];
        end
      end
      KIND_DELETE: begin
        if (hit) begin
          // Close the gap by moving later entries down one slot.
          for (j = slot; j + 1 < held_count; j++) begin
            held_keys[j]   = held_keys[j + 1];
            held_values[j] = held_values[j + 1];
          end
          held_count--;
          r.status = ST_DELETED;
          r.position = slot[3:0];
        end
      end
      default: begin
        if (hit) begin
          r.status = ST_FOUND;
          r.value_out = held_values[slot];
          r.position = slot[3:0];
        end
      end
    endcase
    r.entries_held = held_count[4:0];
    if (held_count > peak_count)
      peak_count = held_count;
    return r;
  endfunction

  // Directed row whose answer is written out by hand.
  function automatic void add_known(kind_e k, logic signed [31:0] key, logic [31:0] v,
                                    status_e s, logic [31:0] vo, logic [3:0] pos,
                                    logic [4:0] held);
    probe_row_t row;
    row.word.kind         = k;
    row.word.key          = key;
    row.word.value_in     = v;
    row.typed             = 1'b1;
    row.answer.status     = s;
    row.answer.value_out  = vo;
    row.answer.position   = pos;
    row.answer.entries_held = held;
    probe_rows.push_back(row);
  endfunction

  // Directed row left to the shadow dictionary.
  function automatic void add_free(kind_e k, logic signed [31:0] key, logic [31:0] v);
    probe_row_t row;
    row = '0;
    row.word.kind     = k;
    row.word.key      = key;
    row.word.value_in = v;
    probe_rows.push_back(row);
  endfunction

  // Favor keys already held so lookups and deletes hit, then extremes, then a
  // small pool so the table fills and drains, and now and then any key at all.
  function automatic logic signed [31:0] pick_key();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (held_count != 0 && roll < 35)
      return held_keys[$urandom_range(0, held_count - 1)];
    if (roll < 45) begin
      case ($urandom_range(0, 3))
        0:       return KeyMin;
        1:       return KeyMax;
        2:       return 32'sd0;
        default: return -32'sd1;
      endcase
    end
    if (roll < 85)
      return key_pool[$urandom_range(0, PoolSize - 1)];
    return $urandom;
  endfunction

  // Present one word, hold it until taken, then record its answer.
  task automatic put_word(input req_t w, input logic typed, input rsp_t answer);
    rsp_t predicted;
    in_word_i  = w;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    predicted = dict_apply(w);
    awaited_answers.push_back(typed ? answer : predicted);
    words_sent++;
    @(negedge clk_i);
  endtask

  // Drop valid for a number of cycles.
  task automatic hold_off(input int unsigned cycles);
    in_valid_i = 1'b0;
    repeat (cycles) @(negedge clk_i);
  endtask

  // Drop valid until every awaited answer is back.
  task automatic drain_answers();
    in_valid_i = 1'b0;
    while (awaited_answers.size() != 0) @(negedge clk_i);
  endtask

  // Receiver back-pressure: switch among no stall, light random, a fixed
  // two-in-five pattern and heavy random, each for a random span.
  always @(negedge clk_i) begin
    if (stall_span == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_span <= $urandom_range(16, 80);
    end else begin
      stall_span <= stall_span - 1;
    end
    case (stall_mode)
      0:       out_stall_i <= 1'b0;
      1:       out_stall_i <= ($urandom_range(0, 2) == 0);
      2:       out_stall_i <= ((cycle_count % 5) < 2);
      default: out_stall_i <= ($urandom_range(0, 2) != 0);
    endcase
  end

  // Compare every taken result word with the oldest awaited answer.
  always @(posedge clk_i) begin
    rsp_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (awaited_answers.size() == 0) begin
        $error("Result word with no answer awaited: %h", out_word_o);
        fail_count++;
      end else begin
        want = awaited_answers.pop_front();
        words_checked++;
        if (want.status < 6)
          outcome_seen[want.status]++;
        if (out_word_o.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_word_o.status);
          fail_count++;
        end
        if (out_word_o.value_out !== want.value_out) begin
          $error("value_out: expected %h, got %h", want.value_out, out_word_o.value_out);
          fail_count++;
        end
        if (out_word_o.position !== want.position) begin
          $error("position: expected %0d, got %0d", want.position, out_word_o.position);
          fail_count++;
        end
        if (out_word_o.entries_held !== want.entries_held) begin
          $error("entries_held: expected %0d, got %0d",
                 want.entries_held, out_word_o.entries_held);
          fail_count++;
        end
      end
    end
  end

  initial begin
    req_t        w;
    rsp_t        none;
    int unsigned burst_left;
    int unsigned roll;
    logic        grow;

    in_valid_i    = 1'b0;
    in_word_i     = '0;
    rst_ni        = 1'b0;
    fail_count    = 0;
    words_sent    = 0;
    words_checked = 0;
    held_count    = 0;
    peak_count    = 0;
    none          = '0;
    burst_left    = 0;
    foreach (outcome_seen[i]) outcome_seen[i] = 0;
    foreach (held_keys[i]) begin
      held_keys[i]   = '0;
      held_values[i] = '0;
    end

    // Seed the key pool with the extremes and neighbors, the rest random.
    key_pool[0] = KeyMin;
    key_pool[1] = KeyMax;
    key_pool[2] = 32'sd0;
    key_pool[3] = -32'sd1;
    key_pool[4] = KeyMin + 32'sd1;
    key_pool[5] = KeyMax - 32'sd1;
    for (int i = 6; i < PoolSize; i++) key_pool[i] = $urandom;

    // Directed part: empty-table misses, extremes, update, spare kind, fill
    // to capacity out of order, reject when full, update when full, deletes.
    add_known(KIND_LOOKUP, 32'sd0, 32'h0, ST_NOT_FOUND, '0, '0, 5'd0);
    add_known(KIND_DELETE, 32'sd5, 32'hffff_ffff, ST_NOT_FOUND, '0, '0, 5'd0);
    add_known(KIND_INSERT, KeyMax, 32'hffff_ffff, ST_INSERTED, '0, 4'd0, 5'd1);
    add_known(KIND_INSERT, KeyMin, 32'h0, ST_INSERTED, '0, 4'd0, 5'd2);
    add_known(KIND_LOOKUP, KeyMax, 32'h0, ST_FOUND, 32'hffff_ffff, 4'd1, 5'd2);
    add_known(KIND_INSERT, KeyMax, 32'h0000_1234, ST_UPDATED, '0, 4'd1, 5'd2);
    add_known(KIND_SPARE, KeyMax, 32'h0, ST_FOUND, 32'h0000_1234, 4'd1, 5'd2);
    add_free(KIND_INSERT, 32'sd0, 32'h1111_1111);
    add_free(KIND_INSERT, -32'sd1, 32'h2222_2222);
    add_free(KIND_INSERT, 32'sd1, 32'h3333_3333);
    add_free(KIND_INSERT, 32'sd1000, 32'h4444_4444);
    add_free(KIND_INSERT, -32'sd1000, 32'h5555_5555);
    add_free(KIND_INSERT, 32'sd500, 32'h6666_6666);
    add_free(KIND_INSERT, -32'sd500, 32'h7777_7777);
    add_free(KIND_INSERT, 32'sd2147483646, 32'h8888_8888);
    add_free(KIND_INSERT, -32'sd2147483647, 32'h9999_9999);
    add_free(KIND_INSERT, 32'sd65536, 32'haaaa_aaaa);
    add_free(KIND_INSERT, -32'sd65536, 32'hbbbb_bbbb);
    add_free(KIND_INSERT, 32'sd7, 32'hcccc_cccc);
    add_free(KIND_INSERT, -32'sd7, 32'hdddd_dddd);
    add_free(KIND_INSERT, 32'sd300, 32'heeee_eeee);
    add_known(KIND_INSERT, 32'sd100, 32'h0bad_0bad, ST_FULL, '0, '0, 5'd16);
    add_free(KIND_INSERT, 32'sd0, 32'h0f0f_0f0f);
    add_known(KIND_DELETE, KeyMin, 32'h0, ST_DELETED, '0, 4'd0, 5'd15);
    add_free(KIND_DELETE, KeyMax, 32'h0);
    add_known(KIND_DELETE, 32'sd100, 32'h0, ST_NOT_FOUND, '0, '0, 5'd14);

    // Hold reset, then release it away from the rising edge.
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (probe_rows[i])
      put_word(probe_rows[i].word, probe_rows[i].typed, probe_rows[i].answer);
    drain_answers();

    // Random part: alternate growing and shrinking epochs so the table
    // swings between empty and full; bursts of words with random gaps.
    for (int n = 0; n < RandWords; n++) begin
      if (n == RandWords / 2)
        drain_answers();
      if (burst_left == 0) begin
        hold_off($urandom_range(0, 6));
        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80)
                                                 : $urandom_range(1, 24);
      end
      burst_left--;
      grow = ((n / 60) % 2) == 0;
      roll = $urandom_range(0, 99);
      if (roll < (grow ? 60 : 15))
        w.kind = KIND_INSERT;
      else if (roll < 75)
        w.kind = KIND_DELETE;
      else if (roll < 95)
        w.kind = KIND_LOOKUP;
      else
        w.kind = KIND_SPARE;
      // Shrinking epochs trade most inserts for deletes.
      if (!grow && w.kind == KIND_DELETE && roll >= 60)
        w.kind = KIND_LOOKUP;
      else if (!grow && roll >= 15 && roll < 60)
        w.kind = KIND_DELETE;
      w.key      = pick_key();
      w.value_in = $urandom;
      put_word(w, 1'b0, none);
    end
    in_valid_i = 1'b0;

    // Wait out the last answers, then keep the clock running to catch strays.
    while (awaited_answers.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);

    $display("Sent %0d words (%0d directed), checked %0d answers; peak fill %0d of %0d.",
             words_sent, probe_rows.size(), words_checked, peak_count, Capacity);
    $display("Outcomes: %0d inserted, %0d updated, %0d found, %0d missed, %0d deleted, %0d full.",
             outcome_seen[ST_INSERTED], outcome_seen[ST_UPDATED], outcome_seen[ST_FOUND],
             outcome_seen[ST_NOT_FOUND], outcome_seen[ST_DELETED], outcome_seen[ST_FULL]);
    if (fail_count == 0 && awaited_answers.size() == 0) begin
      $display("** sorted_table_dictionary: PASSED **");
    end else begin
      $display("** sorted_table_dictionary: FAILED **");
    end
    $finish;
  end

endmodule

[files.f]
src/stdict_pkg.sv
src/stdict_cell.sv
src/sorted_table_dictionary.sv
tb/sv/sorted_table_dictionary_test.sv
